### hdl/ntc_pkg.sv
// Shared types, constants and helpers for the NTC thermistor linearizer.
// Used by the front cells, the reciprocal divider cells and the top level.
package ntc_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int SERIES_W     = 20;
  localparam int FS_W         = 10;
  localparam int RES_W        = 24;
  localparam int KEL_W        = 19;
  localparam int CEL_W        = 20;
  localparam int CFG_IDX_W    = 4;
  localparam int FRAC_BITS    = 24;
  localparam int MANT_W       = 31;
  localparam int EXP_W        = 5;
  localparam int LOG_W        = 29;
  localparam int REM_K_W      = 60;
  localparam int Q_K_W        = 47;

  localparam logic [CFG_IDX_W-1:0] CFG_SERIES     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  localparam logic [SERIES_W-1:0]  SERIES_RESET  = 20'd10000;
  localparam logic [FS_W-1:0]      FS_RESET      = 10'd1023;
  localparam logic [16:0]          DIVIDER_SCALE = 17'd1024;
  localparam logic [31:0]          LN2_Q32       = 32'd2977044472;
  localparam logic [60:0]          LN_RND        = 61'h8000_0000;
  localparam logic signed [63:0]   COEF_A_Q24    = 64'sd11291480000 * 64'sd16777216;
  localparam logic signed [32:0]   COEF_B        = 33'sd2341250000;
  localparam logic signed [20:0]   COEF_C        = 21'sd876741;
  localparam logic [REM_K_W-1:0]   INV_NUM       = 60'd655360000000000000;
  localparam logic [KEL_W-1:0]     KELVIN_MAX    = 19'h7FFFF;
  localparam logic signed [CEL_W-1:0] ZERO_C_Q8  = 20'sd69926;
  localparam logic [RES_W-1:0]     RES_MAX       = 24'hFFFFFF;

  typedef struct packed {
    logic zero;
    logic sat;
    logic kz;
    logic rovf;
  } flags_t;

  typedef struct packed {
    logic [MANT_W-1:0]    ma;
    logic [MANT_W-1:0]    mb;
    logic [FRAC_BITS-1:0] fa;
    logic [FRAC_BITS-1:0] fb;
    logic [EXP_W-1:0]     ea;
    logic [EXP_W-1:0]     eb;
  } log_t;

  typedef struct packed {
    logic [FS_W-1:0]  dn;
    logic [RES_W-1:0] rq;
  } rdiv_t;

  typedef struct packed {
    logic [RES_W-1:0] res;
    status_e          status;
    logic             zero;
    logic             kzero;
    logic             kmax;
  } kside_t;

  // position of the leading one, zero for an input of zero
  function automatic logic [EXP_W-1:0] lead_one(input logic [MANT_W-1:0] x);
    logic [EXP_W-1:0] e;
    e = '0;
    for (int i = 1; i < MANT_W; i++) begin
      if (x[i]) e = EXP_W'(i);
    end
    return e;
  endfunction

endpackage

### hdl/ntc_front_cell.sv
// One front cell: a restoring step of the resistance divider and one squaring
// step of both log2 mantissas. Depends on ntc_pkg.
module ntc_front_cell #(
  parameter int N_W   = 31,
  parameter int SHIFT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  ntc_pkg::flags_t    flags_i,
  input  logic [N_W-1:0]     rem_i,
  input  ntc_pkg::rdiv_t     rdiv_i,
  input  ntc_pkg::log_t      log_i,
  output logic               vld_o,
  output ntc_pkg::flags_t    flags_o,
  output logic [N_W-1:0]     rem_o,
  output ntc_pkg::rdiv_t     rdiv_o,
  output ntc_pkg::log_t      log_o
);

  localparam int CW = (N_W > ntc_pkg::FS_W + SHIFT) ? N_W : ntc_pkg::FS_W + SHIFT;

  logic [CW-1:0]  rem_x, cmp;
  logic           take;
  logic [61:0]    sqa, sqb;
  logic [31:0]    ta, tb;
  logic           vld_q;
  ntc_pkg::flags_t flags_q;
  logic [N_W-1:0] rem_d, rem_q;
  ntc_pkg::rdiv_t rdiv_d, rdiv_q;
  ntc_pkg::log_t  log_d, log_q;

  assign rem_x = CW'(rem_i);
  assign cmp   = CW'(rdiv_i.dn) << SHIFT;
  assign take  = rem_x >= cmp;
  assign rem_d = take ? N_W'(rem_x - cmp) : rem_i;

  assign sqa = 62'(log_i.ma) * 62'(log_i.ma);
  assign sqb = 62'(log_i.mb) * 62'(log_i.mb);
  assign ta  = sqa[61:30];
  assign tb  = sqb[61:30];

  always_comb begin
    rdiv_d    = rdiv_i;
    rdiv_d.rq = {rdiv_i.rq[ntc_pkg::RES_W-2:0], take};
    log_d     = log_i;
    log_d.ma  = ta[31] ? ta[31:1] : ta[30:0];
    log_d.mb  = tb[31] ? tb[31:1] : tb[30:0];
    log_d.fa  = {log_i.fa[ntc_pkg::FRAC_BITS-2:0], ta[31]};
    log_d.fb  = {log_i.fb[ntc_pkg::FRAC_BITS-2:0], tb[31]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q <= flags_i;
      rem_q   <= rem_d;
      rdiv_q  <= rdiv_d;
      log_q   <= log_d;
    end
  end

  assign vld_o   = vld_q;
  assign flags_o = flags_q;
  assign rem_o   = rem_q;
  assign rdiv_o  = rdiv_q;
  assign log_o   = log_q;

endmodule

### hdl/ntc_kdiv_cell.sv
// One restoring step of the reciprocal divider that forms kelvin_q8.
// Depends on ntc_pkg.
module ntc_kdiv_cell #(
  parameter int SHIFT = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  ntc_pkg::kside_t               side_i,
  input  logic [ntc_pkg::REM_K_W-1:0]   rem_i,
  input  logic [ntc_pkg::Q_K_W-1:0]     q_i,
  input  logic [ntc_pkg::KEL_W-1:0]     kq_i,
  output logic                          vld_o,
  output ntc_pkg::kside_t               side_o,
  output logic [ntc_pkg::REM_K_W-1:0]   rem_o,
  output logic [ntc_pkg::Q_K_W-1:0]     q_o,
  output logic [ntc_pkg::KEL_W-1:0]     kq_o
);

  localparam int CW = ntc_pkg::Q_K_W + SHIFT + ntc_pkg::REM_K_W;

  logic [CW-1:0]                 rem_x, cmp;
  logic                          take;
  logic                          vld_q;
  ntc_pkg::kside_t               side_q;
  logic [ntc_pkg::REM_K_W-1:0]   rem_q;
  logic [ntc_pkg::Q_K_W-1:0]     q_q;
  logic [ntc_pkg::KEL_W-1:0]     kq_q;

  assign rem_x = CW'(rem_i);
  assign cmp   = CW'(q_i) << SHIFT;
  assign take  = rem_x >= cmp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rem_q  <= take ? ntc_pkg::REM_K_W'(rem_x - cmp) : rem_i;
      q_q    <= q_i;
      kq_q   <= {kq_i[ntc_pkg::KEL_W-2:0], take};
    end
  end

  assign vld_o  = vld_q;
  assign side_o = side_q;
  assign rem_o  = rem_q;
  assign q_o    = q_q;
  assign kq_o   = kq_q;

endmodule

### hdl/ntc_thermistor_linearizer.sv
// NTC thermistor linearizer: divider resistance and Steinhart-Hart temperature.
// One sample per cycle when the output side takes results; a stalled output
// holds the whole pipeline. Built from 24 front cells (log2 squaring +
// resistance divider) and 19 reciprocal divider cells. Reset clears valid
// bits; registers reset to 10000 ohm, 1023.
// Depends on ntc_pkg, ntc_front_cell and ntc_kdiv_cell.
module ntc_thermistor_linearizer #(
  parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ntc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ntc_pkg::SERIES_W-1:0]      cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // adc_sample
  input  logic [((ADC_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // resistance_ohms, kelvin_q8, celsius_q8
  output logic [63:0]                       m_axis_tdata,
  // status
  output logic [1:0]                        m_axis_tuser
);

  localparam int P_W   = ntc_pkg::SERIES_W + ADC_BITS;
  localparam int N_W   = P_W + 1;
  localparam int OW    = (N_W > 34) ? N_W : 34;
  localparam int NCELL = ntc_pkg::RES_W;
  localparam int KCELL = ntc_pkg::KEL_W;

  logic en;
  logic [ntc_pkg::SERIES_W-1:0] series_q;
  logic [ntc_pkg::FS_W-1:0]     fs_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_q <= ntc_pkg::SERIES_RESET;
      fs_q     <= ntc_pkg::FS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ntc_pkg::CFG_SERIES:     series_q <= cfg_data_i;
        ntc_pkg::CFG_FULL_SCALE: fs_q     <= cfg_data_i[ntc_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits of the non-cell stages: 0 input, 1, 2, P1..P8
  logic [10:0] v_q;

  // stage 0: capture
  logic [ADC_BITS-1:0]          adc0_q;
  logic [ntc_pkg::SERIES_W-1:0] ser0_q;
  logic [ntc_pkg::FS_W-1:0]     fs0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      adc0_q <= s_axis_tdata[ADC_BITS-1:0];
      ser0_q <= series_q;
      fs0_q  <= fs_q;
    end
  end

  // stage 1: flags and products
  logic [16:0]            adc17;
  logic [10:0]            sub;
  ntc_pkg::flags_t        flags1_d, flags1_q;
  logic [ntc_pkg::FS_W-1:0] dn1_q;
  logic [P_W-1:0]         prod1_q;
  logic [ntc_pkg::MANT_W-1:0] num1_q;
  logic [ADC_BITS-1:0]    adc1_q;

  assign adc17 = 17'(adc0_q);
  assign sub   = 11'(ntc_pkg::DIVIDER_SCALE - adc17);

  always_comb begin
    flags1_d.zero = adc17 == 17'd0;
    flags1_d.sat  = adc17 >= 17'(fs0_q);
    flags1_d.kz   = (ser0_q == '0) || (adc17 >= ntc_pkg::DIVIDER_SCALE);
    flags1_d.rovf = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flags1_q <= flags1_d;
      dn1_q    <= ntc_pkg::FS_W'(fs0_q - adc17[9:0]);
      prod1_q  <= P_W'(ser0_q) * P_W'(adc0_q);
      num1_q   <= ntc_pkg::MANT_W'(ser0_q) * ntc_pkg::MANT_W'(sub);
      adc1_q   <= adc0_q;
    end
  end

  // stage 2: rounding numerator, overflow check, normalize mantissas
  logic [N_W-1:0]             n2;
  logic [ntc_pkg::EXP_W-1:0]  ea2, eb2;
  logic [ntc_pkg::MANT_W-1:0] adc31;
  ntc_pkg::flags_t            flags2_d;
  ntc_pkg::log_t              log2_d;
  ntc_pkg::rdiv_t             rdiv2_d;

  logic                   cv    [NCELL+1];
  ntc_pkg::flags_t        cf    [NCELL+1];
  logic [N_W-1:0]         crem  [NCELL+1];
  ntc_pkg::rdiv_t         crd   [NCELL+1];
  ntc_pkg::log_t          clog  [NCELL+1];

  assign n2    = N_W'(prod1_q) + N_W'(dn1_q[ntc_pkg::FS_W-1:1]);
  assign adc31 = ntc_pkg::MANT_W'(adc1_q);
  assign ea2   = ntc_pkg::lead_one(num1_q);
  assign eb2   = ntc_pkg::lead_one(adc31);

  always_comb begin
    flags2_d      = flags1_q;
    flags2_d.rovf = OW'(n2) >= (OW'(dn1_q) << ntc_pkg::RES_W);
    log2_d.ma     = num1_q << (5'd30 - ea2);
    log2_d.mb     = adc31 << (5'd30 - eb2);
    log2_d.fa     = '0;
    log2_d.fb     = '0;
    log2_d.ea     = ea2;
    log2_d.eb     = eb2;
    rdiv2_d.dn    = dn1_q;
    rdiv2_d.rq    = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cf[0]   <= flags2_d;
      crem[0] <= n2;
      crd[0]  <= rdiv2_d;
      clog[0] <= log2_d;
    end
  end
  assign cv[0] = v_q[2];

  for (genvar i = 0; i < NCELL; i++) begin : g_front
    ntc_front_cell #(
      .N_W   (N_W),
      .SHIFT (NCELL - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .vld_i   (cv[i]),
      .flags_i (cf[i]),
      .rem_i   (crem[i]),
      .rdiv_i  (crd[i]),
      .log_i   (clog[i]),
      .vld_o   (cv[i+1]),
      .flags_o (cf[i+1]),
      .rem_o   (crem[i+1]),
      .rdiv_o  (crd[i+1]),
      .log_o   (clog[i+1])
    );
  end

  // P1: natural logs
  logic [ntc_pkg::LOG_W-1:0] la, lb, lna_q, lnb_q;
  logic [60:0]               pa, pb;
  ntc_pkg::flags_t           fp1_q;
  logic [ntc_pkg::RES_W-1:0] rq1_q;

  assign la = {clog[NCELL].ea, clog[NCELL].fa};
  assign lb = {clog[NCELL].eb, clog[NCELL].fb};
  assign pa = 61'(la) * 61'(ntc_pkg::LN2_Q32) + ntc_pkg::LN_RND;
  assign pb = 61'(lb) * 61'(ntc_pkg::LN2_Q32) + ntc_pkg::LN_RND;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lna_q <= pa[60:32];
      lnb_q <= pb[60:32];
      fp1_q <= cf[NCELL];
      rq1_q <= crd[NCELL].rq;
    end
  end

  // P2: ln R and final resistance
  logic signed [29:0] x_q, x3x_q, x4x_q;
  ntc_pkg::kside_t    sd2, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q;

  always_comb begin
    sd2.zero  = fp1_q.zero;
    sd2.kzero = fp1_q.kz;
    sd2.kmax  = 1'b0;
    if (fp1_q.zero) begin
      sd2.res    = '0;
      sd2.status = ntc_pkg::ST_ZERO;
    end else if (fp1_q.sat) begin
      sd2.res    = ntc_pkg::RES_MAX;
      sd2.status = ntc_pkg::ST_SAT;
    end else begin
      sd2.res    = fp1_q.rovf ? ntc_pkg::RES_MAX : rq1_q;
      sd2.status = ntc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q  <= $signed({1'b0, lna_q}) - $signed({1'b0, lnb_q});
      s2_q <= sd2;
    end
  end

  // P3: square
  logic signed [59:0] xx;
  logic [33:0]        x2_q;
  assign xx = 60'(x_q) * 60'(x_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q  <= xx[57:24];
      x3x_q <= x_q;
      s3_q  <= s2_q;
    end
  end

  // P4: cube, floored
  logic signed [63:0] pc;
  logic signed [38:0] x3_q;
  assign pc = 64'($signed({1'b0, x2_q})) * 64'(x3x_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x3_q  <= pc[62:24];
      x4x_q <= x3x_q;
      s4_q  <= s3_q;
    end
  end

  // P5: coefficient products
  logic signed [62:0] bx_q;
  logic signed [59:0] cx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bx_q  <= 63'(ntc_pkg::COEF_B) * 63'(x4x_q);
      cx_q  <= 60'(ntc_pkg::COEF_C) * 60'(x3_q);
      s5_q  <= s4_q;
    end
  end

  // P6: denominator
  logic signed [63:0] d_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q  <= ntc_pkg::COEF_A_Q24 + 64'(bx_q) + 64'(cx_q);
      s6_q <= s5_q;
    end
  end

  // P7: divisor and rounded dividend
  logic [ntc_pkg::Q_K_W-1:0]   q7, q7_q, q8_q;
  logic [ntc_pkg::REM_K_W-1:0] nk7_q, nk8_q;
  ntc_pkg::kside_t             sd7, sd8, s8_q;

  assign q7 = d_q[62:16];

  always_comb begin
    sd7       = s6_q;
    sd7.kzero = s6_q.kzero || d_q[63];
    sd7.kmax  = q7 == '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q7_q  <= q7;
      nk7_q <= ntc_pkg::INV_NUM + ntc_pkg::REM_K_W'(q7[ntc_pkg::Q_K_W-1:1]);
      s7_q  <= sd7;
    end
  end

  // P8: quotient overflow check
  always_comb begin
    sd8      = s7_q;
    sd8.kmax = s7_q.kmax ||
               (66'(nk7_q) >= {q7_q, {ntc_pkg::KEL_W{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q8_q  <= q7_q;
      nk8_q <= nk7_q;
      s8_q  <= sd8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[9:3], cv[NCELL], v_q[1:0], s_axis_tvalid};
    end
  end

  logic                        kv   [KCELL+1];
  ntc_pkg::kside_t             ks   [KCELL+1];
  logic [ntc_pkg::REM_K_W-1:0] krem [KCELL+1];
  logic [ntc_pkg::Q_K_W-1:0]   kqd  [KCELL+1];
  logic [ntc_pkg::KEL_W-1:0]   kq   [KCELL+1];

  assign kv[0]   = v_q[10];
  assign ks[0]   = s8_q;
  assign krem[0] = nk8_q;
  assign kqd[0]  = q8_q;
  assign kq[0]   = '0;

  for (genvar j = 0; j < KCELL; j++) begin : g_kdiv
    ntc_kdiv_cell #(
      .SHIFT (KCELL - 1 - j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (kv[j]),
      .side_i (ks[j]),
      .rem_i  (krem[j]),
      .q_i    (kqd[j]),
      .kq_i   (kq[j]),
      .vld_o  (kv[j+1]),
      .side_o (ks[j+1]),
      .rem_o  (krem[j+1]),
      .q_o    (kqd[j+1]),
      .kq_o   (kq[j+1])
    );
  end

  // output register
  ntc_pkg::kside_t               sf;
  logic [ntc_pkg::KEL_W-1:0]     kel;
  logic signed [ntc_pkg::CEL_W-1:0] cel;
  logic [63:0]                   tdata_q;
  logic [1:0]                    tuser_q;
  logic                          tvalid_q;

  assign sf  = ks[KCELL];
  assign kel = (sf.zero || sf.kzero) ? '0 : (sf.kmax ? ntc_pkg::KELVIN_MAX : kq[KCELL]);
  assign cel = sf.zero ? '0 : $signed({1'b0, kel}) - ntc_pkg::ZERO_C_Q8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (en) begin
      tvalid_q <= kv[KCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= {1'b0, cel, kel, sf.res};
      tuser_q <= sf.status;
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

endmodule

### tb/tb.sv
// Self-checking testbench for ntc_thermistor_linearizer: resistance, Kelvin and Celsius.
// Depends on ntc_pkg and the linearizer RTL; holds its own bit-true converter model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  class conv_board;
    logic [63:0] pend_data[$];
    logic [1:0]  pend_stat[$];
    int          errors = 0;
    int          shown = 0;

    function void note(logic [63:0] d, logic [1:0] st);
      pend_data.push_back(d);
      pend_stat.push_back(st);
    endfunction

    function void check(logic [63:0] d, logic [1:0] st);
      logic [63:0] ed;
      logic [1:0]  es;
      if (pend_data.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result data=%h status=%0d", d, st);
        end
        return;
      end
      ed = pend_data.pop_front();
      es = pend_stat.pop_front();
      if (ed[23:0] !== d[23:0] || ed[42:24] !== d[42:24] || ed[62:43] !== d[62:43]
          || ed[63] !== d[63] || es !== st) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch res exp %0d got %0d, kel exp %0d got %0d,",
                   ed[23:0], d[23:0], ed[42:24], d[42:24]);
          $display("  cel exp %h got %h, st exp %0d got %0d",
                   ed[62:43], d[62:43], es, st);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ntc_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ntc_pkg::SERIES_W-1:0]  cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  always #1 clk_i = ~clk_i;

  ntc_thermistor_linearizer dut (.*);

  conv_board board = new();
  logic [19:0] series_r = 20'd10000;
  logic [9:0]  fs_r = 10'd1023;
  bit quiet = 1'b0;
  bit hold_long = 1'b0;
  int idle_cnt = 0;
  int rdy_gap = 0;

  function automatic logic [63:0] log2_q24(logic [63:0] x);
    int unsigned e;
    logic [63:0] m, frac;
    e = 0;
    frac = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
    for (int i = 0; i < ntc_pkg::FRAC_BITS; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(e) << ntc_pkg::FRAC_BITS) | frac;
  endfunction

  function automatic longint ln_q24(logic [63:0] x);
    logic [63:0] p;
    p = log2_q24(x) * 64'd2977044472 + (64'd1 << 31);
    return longint'(p >> 32);
  endfunction

  function automatic longint kelvin_of(logic [9:0] adc);
    logic [63:0] num, q, t;
    longint x, x2, x3, d, p;
    if (series_r == 0) return 0;
    num = 64'(series_r) * (64'd1024 - 64'(adc));
    x = ln_q24(num) - ln_q24(64'(adc));
    x2 = (x * x) >>> ntc_pkg::FRAC_BITS;
    p = x2 * x;
    x3 = p >>> ntc_pkg::FRAC_BITS;  // arithmetic shift floors
    d = 64'sd11291480000 * 64'sd16777216 + 64'sd2341250000 * x + 64'sd876741 * x3;
    if (d < 0) return 0;
    q = 64'(d) >> 16;
    if (q == 0) return 524287;
    t = (64'd655360000000000000 + q / 2) / q;
    if (t > 64'd524287) return 524287;
    return longint'(t);
  endfunction

  task automatic predict_sample(logic [9:0] adc);
    logic [63:0] res, n, dn;
    logic [1:0] st;
    longint k, c;
    if (adc == 0) begin
      board.note(64'd0, ntc_pkg::ST_ZERO);
      return;
    end
    st = ntc_pkg::ST_OK;
    if (adc >= fs_r) begin
      res = 64'(ntc_pkg::RES_MAX);
      st = ntc_pkg::ST_SAT;
    end else begin
      n = 64'(series_r) * 64'(adc);
      dn = 64'(fs_r - adc);
      res = (n + dn / 2) / dn;
      if (res > 64'(ntc_pkg::RES_MAX)) res = 64'(ntc_pkg::RES_MAX);
    end
    k = kelvin_of(adc);
    c = k - 69926;
    board.note({1'b0, c[19:0], k[18:0], res[23:0]}, st);
  endtask

  task automatic write_reg(logic [ntc_pkg::CFG_IDX_W-1:0] idx, logic [19:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == ntc_pkg::CFG_SERIES) series_r = val;
    else if (idx == ntc_pkg::CFG_FULL_SCALE) fs_r = val[9:0];
  endtask

  task automatic send_sample(logic [9:0] adc);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, adc};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_sample(adc);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pend_data.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send_sample(10'($urandom_range(0, 3)));
        1: send_sample(10'($urandom_range(1020, 1023)));
        2: send_sample(fs_r);
        default: send_sample(10'($urandom));
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check(m_axis_tdata, m_axis_tuser);
  end

  // receiver idles in bursts of random length
  always @(posedge clk_i) begin
    if (hold_long) begin
      m_axis_tready <= 1'b0;
    end else if (rdy_gap > 0) begin
      m_axis_tready <= 1'b0;
      rdy_gap <= rdy_gap - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      rdy_gap <= $urandom_range(0, 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 5000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int hold;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: field extremes and the special cases
    send_sample(10'd0);
    send_sample(10'd1);
    send_sample(10'd2);
    send_sample(10'h155);
    send_sample(10'h2AA);
    send_sample(10'd512);
    send_sample(10'd1022);
    send_sample(10'd1023);
    drain();
    write_reg(ntc_pkg::CFG_SERIES, 20'hFFFFF);
    write_reg(ntc_pkg::CFG_FULL_SCALE, 20'd1);
    send_sample(10'd1);
    send_sample(10'd5);
    send_sample(10'd1);
    drain();
    write_reg(ntc_pkg::CFG_SERIES, 20'd0);
    write_reg(ntc_pkg::CFG_FULL_SCALE, 20'd512);
    send_sample(10'd100);
    send_sample(10'd600);
    drain();
    write_reg(ntc_pkg::CFG_SERIES, 20'd1);
    write_reg(ntc_pkg::CFG_FULL_SCALE, 20'd1023);
    // unknown index leaves both registers alone
    write_reg(4'd9, 20'd77);
    send_sample(10'd1);
    send_sample(10'd1000);
    drain();
    // random settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(ntc_pkg::CFG_SERIES,
                (ph == 4) ? 20'd10000 : 20'($urandom_range(1, 1048575)));
      write_reg(ntc_pkg::CFG_FULL_SCALE, 20'($urandom_range(1, 1023)));
      random_phase(130);
      drain();
    end
    // hold the output long so the pipeline fills and stalls its input
    fork
      begin
        hold_long = 1'b1;
        hold = 0;
        while (hold < 300) begin
          @(posedge clk_i);
          hold++;
        end
        hold_long = 1'b0;
      end
      random_phase(80);
    join
    drain();
    quiet = 1'b1;
    random_phase(70);
    drain();
    if (board.errors == 0 && board.pend_data.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

### files.f
hdl/ntc_pkg.sv
hdl/ntc_front_cell.sv
hdl/ntc_kdiv_cell.sv
hdl/ntc_thermistor_linearizer.sv
tb/tb.sv
